// File: rtl/core/uitfb_pkg.sv
`default_nettype none

package uitfb_pkg;

  // Buffer depths and derived widths
  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);
  localparam int TX_CW    = $clog2(TX_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_MAX        = 2'd1;

  // Reset values of the configuration registers
  localparam logic [15:0] SILENCE_RESET = 16'd35;
  localparam logic [8:0]  RX_MAX_RESET  = 9'd256;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  // Command codes, as carried in the action field
  typedef enum logic [3:0] {
    OP_RX_BYTE    = 4'd0,
    OP_TICK       = 4'd1,
    OP_READ_RX    = 4'd2,
    OP_CLEAR_RX   = 4'd3,
    OP_TAKE_FIRST = 4'd4,
    OP_WRITE_TX   = 4'd5,
    OP_START_TX   = 4'd6,
    OP_SEND_CHAR  = 4'd7,
    OP_TX_READY   = 4'd8,
    OP_NONE       = 4'd15
  } op_t;

  // Input transaction payload
  typedef struct packed {
    logic [3:0] action;
    logic [7:0] data_byte;
    logic [7:0] index;
    logic [8:0] length;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       accepted;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [8:0] frame_len;
    logic       tx_busy;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic [7:0] index;
    logic [8:0] length;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/uart_idle_timeout_frame_buffer_top.sv
// Channel   Direction  Handshake               Payload
// in_       input      start, busy             in_data  (in_item_t)
// out_      output     out_valid strobe        out_data (out_item_t)
// cfg_      input      cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One transaction is accepted per cycle while busy is low; its result strobes
// out_valid after the queue stage and then the registered buffer read.
// A two-entry command queue separates the classifier from the executor, which
// drains one command per cycle, so busy rises only if the queue fills.
// Reset (rst_n low, synchronous) empties the queue and clears all counters;
// buffer contents are undefined until written. The receiver cannot stall.
`default_nettype none

module uart_idle_timeout_frame_buffer_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire uitfb_pkg::in_item_t              in_data,
  output logic                                  out_valid,
  output uitfb_pkg::out_item_t                  out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [uitfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                      cfg_data
);

  logic            cmd_valid;
  uitfb_pkg::cmd_t cmd;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  uitfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  uitfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/uitfb_front.sv
`default_nettype none

module uitfb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire uitfb_pkg::in_item_t in_data,
  output logic                    cmd_valid,
  output uitfb_pkg::cmd_t         cmd
);

  uitfb_pkg::cmd_t q_mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;
  uitfb_pkg::cmd_t cls;

  // Classify the action; unused codes become a no-op
  always_comb begin
    cls.op        = (in_data.action <= uitfb_pkg::OP_TX_READY) ?
                    uitfb_pkg::op_t'(in_data.action) : uitfb_pkg::OP_NONE;
    cls.data_byte = in_data.data_byte;
    cls.index     = in_data.index;
    cls.length    = in_data.length;
  end

  // Two-entry queue; the back end drains one command per cycle
  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign pop       = (cnt_r != 2'd0);
  assign cmd_valid = pop;
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/uitfb_back.sv
`default_nettype none

module uitfb_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cmd_valid,
  input  wire uitfb_pkg::cmd_t                       cmd,
  input  wire logic                                  cfg_wr,
  input  wire logic [uitfb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [15:0]                           cfg_data,
  output logic                                       out_valid,
  output uitfb_pkg::out_item_t                       out_data
);

  localparam int RX_AW = uitfb_pkg::RX_AW;
  localparam int TX_AW = uitfb_pkg::TX_AW;
  localparam int RX_CW = uitfb_pkg::RX_CW;
  localparam int TX_CW = uitfb_pkg::TX_CW;

  // Frame buffers
  logic [7:0] rx_mem [uitfb_pkg::RX_DEPTH];
  logic [7:0] tx_mem [uitfb_pkg::TX_DEPTH];

  // Configuration
  logic [15:0] silence_r;
  logic [8:0]  rx_max_r;

  // Channel state
  logic [RX_CW-1:0] rx_count_r, rx_count_nxt;
  logic [RX_CW-1:0] frame_len_r, frame_len_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [TX_CW-1:0] tx_sent_r, tx_sent_nxt;
  logic [TX_CW-1:0] tx_total_r, tx_total_nxt;

  // Result stage
  logic       ob_valid_r, ob_valid_nxt;
  logic       ob_txv_r, ob_txv_nxt;
  logic       ob_tx_mem_r, ob_tx_mem_nxt;
  logic [7:0] ob_tx_data_r, ob_tx_data_nxt;
  logic       ob_acc_r, ob_acc_nxt;
  logic       ob_rxv_r, ob_rxv_nxt;
  logic       ob_rx_use_r, ob_rx_use_nxt;
  logic [7:0] rx_rd_r, tx_rd_r;

  // Memory access controls
  logic             rx_we, tx_we, rx_re, tx_re;
  logic [RX_AW-1:0] rx_wa, rx_ra;
  logic [TX_AW-1:0] tx_wa, tx_ra;

  logic [RX_CW-1:0] rx_limit;
  logic [TX_CW-1:0] tx_len;
  logic [15:0]      idle_inc;

  // Effective receive limit, clamped transmit length and saturating idle count
  always_comb begin
    rx_limit = (32'(rx_max_r) > 32'(uitfb_pkg::RX_DEPTH)) ?
               RX_CW'(uitfb_pkg::RX_DEPTH) : RX_CW'(rx_max_r);
    tx_len   = (32'(cmd.length) > 32'(uitfb_pkg::TX_DEPTH)) ?
               TX_CW'(uitfb_pkg::TX_DEPTH) : TX_CW'(cmd.length);
    idle_inc = (idle_r == uitfb_pkg::IDLE_MAX) ? idle_r : idle_r + 16'd1;
  end

  // Command execution: state update and memory access controls
  always_comb begin
    rx_count_nxt   = rx_count_r;
    frame_len_nxt  = frame_len_r;
    idle_nxt       = idle_r;
    tx_sent_nxt    = tx_sent_r;
    tx_total_nxt   = tx_total_r;
    ob_valid_nxt   = cmd_valid;
    ob_txv_nxt     = 1'b0;
    ob_tx_mem_nxt  = 1'b0;
    ob_tx_data_nxt = 8'd0;
    ob_acc_nxt     = 1'b0;
    ob_rxv_nxt     = 1'b0;
    ob_rx_use_nxt  = 1'b0;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_re          = 1'b0;
    rx_wa          = rx_count_r[RX_AW-1:0];
    rx_ra          = RX_AW'(cmd.index);
    tx_wa          = TX_AW'(cmd.index);
    tx_ra          = tx_sent_r[TX_AW-1:0];
    if (cmd_valid) begin
      case (cmd.op)
        uitfb_pkg::OP_RX_BYTE: begin
          idle_nxt = 16'd0;
          if (frame_len_r == '0 && rx_count_r < rx_limit) begin
            rx_we        = 1'b1;
            rx_count_nxt = rx_count_r + RX_CW'(1);
          end
        end
        uitfb_pkg::OP_TICK: begin
          if (frame_len_r == '0 && rx_count_r != '0) begin
            idle_nxt = idle_inc;
            if (idle_inc >= silence_r) begin
              frame_len_nxt = rx_count_r;
            end
          end
        end
        uitfb_pkg::OP_READ_RX: begin
          rx_re         = 1'b1;
          ob_rx_use_nxt = (32'(cmd.index) < 32'(uitfb_pkg::RX_DEPTH));
          ob_rxv_nxt    = (32'(cmd.index) < 32'(rx_count_r));
        end
        uitfb_pkg::OP_CLEAR_RX: begin
          rx_count_nxt  = '0;
          frame_len_nxt = '0;
          idle_nxt      = 16'd0;
        end
        uitfb_pkg::OP_TAKE_FIRST: begin
          if (rx_count_r != '0) begin
            rx_re         = 1'b1;
            rx_ra         = '0;
            ob_rx_use_nxt = 1'b1;
            ob_rxv_nxt    = 1'b1;
            rx_count_nxt  = '0;
            frame_len_nxt = '0;
            idle_nxt      = 16'd0;
          end
        end
        uitfb_pkg::OP_WRITE_TX: begin
          tx_we = (32'(cmd.index) < 32'(uitfb_pkg::TX_DEPTH));
        end
        uitfb_pkg::OP_START_TX: begin
          if (tx_total_r == '0) begin
            tx_total_nxt  = tx_len;
            tx_sent_nxt   = TX_CW'(1);
            tx_re         = 1'b1;
            tx_ra         = '0;
            ob_txv_nxt    = 1'b1;
            ob_tx_mem_nxt = 1'b1;
            ob_acc_nxt    = 1'b1;
          end
        end
        uitfb_pkg::OP_SEND_CHAR: begin
          if (tx_total_r == '0) begin
            ob_txv_nxt     = 1'b1;
            ob_tx_data_nxt = cmd.data_byte;
            ob_acc_nxt     = 1'b1;
          end
        end
        uitfb_pkg::OP_TX_READY: begin
          if (tx_total_r != '0) begin
            if (tx_sent_r < tx_total_r &&
                32'(tx_sent_r) < 32'(uitfb_pkg::TX_DEPTH)) begin
              tx_re         = 1'b1;
              ob_txv_nxt    = 1'b1;
              ob_tx_mem_nxt = 1'b1;
              tx_sent_nxt   = tx_sent_r + TX_CW'(1);
            end else begin
              tx_total_nxt = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration writes; other indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r <= uitfb_pkg::SILENCE_RESET;
      rx_max_r  <= uitfb_pkg::RX_MAX_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == uitfb_pkg::CFG_SILENCE_TICKS) begin
        silence_r <= cfg_data;
      end
      if (cfg_index == uitfb_pkg::CFG_RX_MAX) begin
        rx_max_r <= cfg_data[8:0];
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r  <= '0;
      frame_len_r <= '0;
      idle_r      <= 16'd0;
      tx_sent_r   <= '0;
      tx_total_r  <= '0;
      ob_valid_r  <= 1'b0;
      ob_txv_r    <= 1'b0;
      ob_tx_mem_r <= 1'b0;
      ob_acc_r    <= 1'b0;
      ob_rxv_r    <= 1'b0;
      ob_rx_use_r <= 1'b0;
    end else begin
      rx_count_r  <= rx_count_nxt;
      frame_len_r <= frame_len_nxt;
      idle_r      <= idle_nxt;
      tx_sent_r   <= tx_sent_nxt;
      tx_total_r  <= tx_total_nxt;
      ob_valid_r  <= ob_valid_nxt;
      ob_txv_r    <= ob_txv_nxt;
      ob_tx_mem_r <= ob_tx_mem_nxt;
      ob_acc_r    <= ob_acc_nxt;
      ob_rxv_r    <= ob_rxv_nxt;
      ob_rx_use_r <= ob_rx_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_tx_data_r <= ob_tx_data_nxt;
  end

  // Receive buffer
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wa] <= cmd.data_byte;
    end
    if (rx_re) begin
      rx_rd_r <= rx_mem[rx_ra];
    end
  end

  // Transmit buffer
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wa] <= cmd.data_byte;
    end
    if (tx_re) begin
      tx_rd_r <= tx_mem[tx_ra];
    end
  end

  // Result transaction; status fields already reflect the finished command
  assign out_valid = ob_valid_r;
  always_comb begin
    out_data.tx_valid  = ob_txv_r;
    out_data.tx_byte   = ob_tx_mem_r ? tx_rd_r : ob_tx_data_r;
    out_data.accepted  = ob_acc_r;
    out_data.rx_valid  = ob_rxv_r;
    out_data.rx_byte   = ob_rx_use_r ? rx_rd_r : 8'd0;
    out_data.frame_len = 9'(frame_len_r);
    out_data.tx_busy   = (tx_total_r != '0);
  end

  // Every command yields one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |=> ob_valid_r)
    else $error("command without result");

  // A closed frame keeps exactly the bytes counted
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    frame_len_r != '0 |-> frame_len_r == rx_count_r)
    else $error("frame length differs from byte count");

  // Receive count never passes the buffer depth
  a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rx_count_r) <= 32'(uitfb_pkg::RX_DEPTH))
    else $error("receive count overflow");

  // An accepted start or single character always hands a byte over
  a_acc_tx: assert property (@(posedge clk) disable iff (!rst_n)
    ob_acc_r |-> ob_txv_r && ob_valid_r)
    else $error("accepted without transmit byte");

  // A byte hand-over during a buffered run advances the send pointer
  a_tx_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd.op == uitfb_pkg::OP_TX_READY && tx_re) |=>
      tx_sent_r == $past(tx_sent_r) + TX_CW'(1))
    else $error("send pointer did not advance");

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import uitfb_pkg::*;

  localparam int IDLE_LIMIT   = 1000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 4;
  localparam logic [3:0] ACT_SPARE_LO = 4'd9;  // first unused action code

  // One queued command with the status it must produce
  typedef struct packed {
    in_item_t  cmd;
    out_item_t status;
  } uart_event_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  in_item_t             in_data   = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;
  logic                 busy;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_ready;

  uart_event_t pending_events[$];
  out_item_t   expected_status[$];
  out_item_t   due;
  int          errors       = 0;
  int          queued_items = 0;
  int          quiet_cycles = 0;
  int          sender_gap   = 0;
  bit          drain_hold   = 1'b0;
  bit          send_now;
  bit          calm         = 1'b0;  // no sender idling in the closing phase

  // Shadow of the frame buffers, counters and registers
  logic [7:0]          rx_mem [RX_DEPTH];
  logic [7:0]          tx_mem [TX_DEPTH];
  bit                  rx_written [RX_DEPTH];
  bit                  tx_written [TX_DEPTH];
  logic [RX_CW-1:0]    rx_cnt;
  logic [RX_CW-1:0]    rx_closed_len;
  logic [15:0]         idle_ticks;
  logic [TX_CW-1:0]    tx_pos;
  logic [TX_CW-1:0]    tx_len;
  logic [15:0]         silence_reg;
  logic [RX_CW-1:0]    rx_max_reg;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  uart_idle_timeout_frame_buffer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Advance the shadow state by one command and return its status word
  function automatic out_item_t apply_uart_event(in_item_t c);
    out_item_t        r;
    logic [RX_CW-1:0] limit;
    r = '0;
    limit = (rx_max_reg > RX_DEPTH) ? RX_CW'(RX_DEPTH) : rx_max_reg;
    case (op_t'(c.action))
      OP_RX_BYTE: begin
        idle_ticks = '0;
        if (rx_closed_len == 0 && rx_cnt < limit) begin
          rx_mem[rx_cnt[RX_AW-1:0]] = c.data_byte;
          rx_written[rx_cnt[RX_AW-1:0]] = 1'b1;
          rx_cnt++;
        end
      end
      OP_TICK: begin
        // only an open frame with bytes counts silence
        if (rx_closed_len == 0 && rx_cnt != 0) begin
          if (idle_ticks < IDLE_MAX) idle_ticks++;
          if (idle_ticks >= silence_reg) rx_closed_len = rx_cnt;
        end
      end
      OP_READ_RX: begin
        r.rx_byte  = rx_mem[c.index];
        r.rx_valid = (c.index < rx_cnt);
      end
      OP_CLEAR_RX: begin
        rx_cnt        = '0;
        rx_closed_len = '0;
        idle_ticks    = '0;
      end
      OP_TAKE_FIRST: begin
        if (rx_cnt != 0) begin
          r.rx_valid    = 1'b1;
          r.rx_byte     = rx_mem[0];
          rx_cnt        = '0;
          rx_closed_len = '0;
          idle_ticks    = '0;
        end
      end
      OP_WRITE_TX: begin
        tx_mem[c.index]     = c.data_byte;
        tx_written[c.index] = 1'b1;
      end
      OP_START_TX: begin
        // entry 0 goes out at once; oversized lengths clamp to the buffer
        if (tx_len == 0) begin
          tx_len     = (c.length > TX_DEPTH) ? TX_CW'(TX_DEPTH) : c.length;
          tx_pos     = TX_CW'(1);
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_mem[0];
          r.accepted = 1'b1;
        end
      end
      OP_SEND_CHAR: begin
        if (tx_len == 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = c.data_byte;
          r.accepted = 1'b1;
        end
      end
      OP_TX_READY: begin
        if (tx_len != 0) begin
          if (tx_pos < tx_len && tx_pos < TX_DEPTH) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = tx_mem[tx_pos[TX_AW-1:0]];
            tx_pos++;
          end else begin
            tx_len = '0;
          end
        end
      end
      default: ;
    endcase
    r.frame_len = rx_closed_len;
    r.tx_busy   = (tx_len != 0);
    return r;
  endfunction

  function automatic int tx_prefix();
    for (int k = 0; k < TX_DEPTH; k++)
      if (!tx_written[k]) return k;
    return TX_DEPTH;
  endfunction

  task automatic queue_event(input logic [3:0] act, input logic [7:0] data,
                             input logic [7:0] idx, input logic [8:0] len);
    uart_event_t ev;
    ev.cmd.action    = act;
    ev.cmd.data_byte = data;
    ev.cmd.index     = idx;
    ev.cmd.length    = len;
    ev.status        = apply_uart_event(ev.cmd);
    pending_events.push_back(ev);
    if (act <= OP_TX_READY) queued_items++;
  endtask

  // Command whose other fields are don't-care, filled at random
  task automatic queue_op(input logic [3:0] act);
    queue_event(act, 8'($urandom), 8'($urandom), 9'($urandom));
  endtask

  // Read only entries that have been written at some point
  task automatic queue_read_rx();
    int base;
    base = ($urandom_range(0, 3) != 0) ? $urandom_range(0, rx_cnt) : $urandom_range(0, 255);
    for (int k = 0; k < RX_DEPTH; k++)
      if (rx_written[(base + k) % RX_DEPTH]) begin
        queue_event(OP_READ_RX, 8'($urandom), 8'((base + k) % RX_DEPTH), 9'($urandom));
        return;
      end
  endtask

  // Start tx with a length whose entries are all written, unless it will bounce
  task automatic queue_start_tx(input logic [8:0] len);
    int p;
    if (tx_len == 0) begin
      if (!tx_written[0]) queue_event(OP_WRITE_TX, 8'($urandom), 8'h00, 9'($urandom));
      p = tx_prefix();
      if (p < TX_DEPTH) len = 9'(len % (p + 1));
    end
    queue_event(OP_START_TX, 8'($urandom), 8'($urandom), len);
  endtask

  // Bytes, silence, host reads, then take first, clear or neither
  task automatic rx_frame_burst();
    int          n, k, lim;
    int unsigned s;
    lim = (rx_max_reg > RX_DEPTH) ? RX_DEPTH : int'(rx_max_reg);
    s   = silence_reg;
    if (rx_cnt != 0 && $urandom_range(0, 3) != 0) queue_op(OP_CLEAR_RX);
    k = $urandom_range(0, 19);
    if (k == 0) n = $urandom_range(1, 262);
    else if (k < 3) n = lim + $urandom_range(0, 2);
    else n = $urandom_range(1, 8);
    if (n == 0) n = 1;
    for (k = 0; k < n; k++) begin
      queue_op(OP_RX_BYTE);
      if (s > 1 && $urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, (s > 4) ? 3 : s - 1)) queue_op(OP_TICK);
    end
    if (s > 48) begin
      repeat ($urandom_range(1, 48)) queue_op(OP_TICK);
    end else begin
      // sometimes a late byte just before the frame would close
      if (s > 1 && $urandom_range(0, 4) == 0) begin
        repeat (s - 1) queue_op(OP_TICK);
        queue_op(OP_RX_BYTE);
      end
      repeat (((s == 0) ? 1 : s) + $urandom_range(0, 2)) queue_op(OP_TICK);
    end
    repeat ($urandom_range(1, 4)) queue_read_rx();
    if ($urandom_range(0, 2) == 0) queue_op(OP_RX_BYTE);
    k = $urandom_range(0, 7);
    if (k < 4) queue_op(OP_TAKE_FIRST);
    else if (k < 6) queue_op(OP_CLEAR_RX);
    else if (k == 6) repeat (2) queue_op(OP_TAKE_FIRST);
  endtask

  // Fill a buffer prefix, start, and drain with ready events
  task automatic tx_burst();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    if (tx_len == 0)
      for (int k = 0; k < ((n == 0) ? 1 : n); k++)
        queue_event(OP_WRITE_TX, 8'($urandom), 8'(k), 9'($urandom));
    queue_start_tx(9'(n));
    while (tx_len != 0) begin
      case ($urandom_range(0, 9))
        0:       queue_op(OP_SEND_CHAR);
        1:       queue_start_tx(9'($urandom));
        2:       queue_op(OP_WRITE_TX);
        default: queue_op(OP_TX_READY);
      endcase
    end
  endtask

  task automatic noise_item();
    logic [3:0] act;
    act = 4'($urandom);
    if (act == OP_READ_RX) queue_read_rx();
    else if (act == OP_START_TX) queue_start_tx(9'($urandom));
    else queue_op(act);
  endtask

  task automatic run_traffic(input int n_items);
    int stop, r;
    stop = queued_items + n_items;
    while (queued_items < stop) begin
      r = $urandom_range(0, 19);
      if (r < 8) rx_frame_burst();
      else if (r < 13) tx_burst();
      else if (r < 15) queue_op(OP_SEND_CHAR);
      else repeat ($urandom_range(1, 3)) noise_item();
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SILENCE_TICKS) silence_reg = val;
    else if (idx == CFG_RX_MAX) rx_max_reg = val[8:0];
  endtask

  // Registers change only with the block drained
  task automatic configure(input logic [15:0] ticks, input logic [15:0] max_bytes);
    wait_drained();
    write_reg(CFG_SILENCE_TICKS, ticks);
    write_reg(CFG_RX_MAX, max_bytes);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Command driver: oldest pending command, random pauses and drain holds
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      sender_gap = 0;
      drain_hold = 1'b0;
    end else begin
      if (start && !busy) begin
        expected_status.push_back(pending_events[0].status);
        void'(pending_events.pop_front());
        if (!calm && $urandom_range(0, 149) == 0) drain_hold = 1'b1;
      end
      if (drain_hold && expected_status.size() == 0) drain_hold = 1'b0;
      if (!(start && busy)) begin
        if (sender_gap > 0) sender_gap--;
        else if (!calm && $urandom_range(0, 11) == 0) sender_gap = $urandom_range(1, 17);
      end
      send_now = (start && busy) ||
                 (sender_gap == 0 && !drain_hold && pending_events.size() != 0);
      start <= send_now;
      if (send_now) in_data <= pending_events[0].cmd;
    end
  end

  // Result monitor: every strobe is compared with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected none, actual %h", $time, out_data);
      end else begin
        due = expected_status.pop_front();
        check_field("tx_valid",  9'(due.tx_valid),  9'(out_data.tx_valid));
        check_field("tx_byte",   9'(due.tx_byte),   9'(out_data.tx_byte));
        check_field("accepted",  9'(due.accepted),  9'(out_data.accepted));
        check_field("rx_valid",  9'(due.rx_valid),  9'(out_data.rx_valid));
        check_field("rx_byte",   9'(due.rx_byte),   9'(out_data.rx_byte));
        check_field("frame_len", due.frame_len,     out_data.frame_len);
        check_field("tx_busy",   9'(due.tx_busy),   9'(out_data.tx_busy));
      end
    end
  end

  // Watchdog on cycles where no transaction of any kind happens
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rx_cnt        = '0;
    rx_closed_len = '0;
    idle_ticks    = '0;
    tx_pos        = '0;
    tx_len        = '0;
    silence_reg   = SILENCE_RESET;
    rx_max_reg    = RX_MAX_RESET;
    for (int k = 0; k < RX_DEPTH; k++) begin
      rx_mem[k]     = '0;
      rx_written[k] = 1'b0;
    end
    for (int k = 0; k < TX_DEPTH; k++) begin
      tx_mem[k]     = '0;
      tx_written[k] = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle corners, tx start/busy rules, frame close and drop
    configure(16'd1, 16'(RX_MAX_RESET));
    queue_op(OP_TX_READY);                               // ready while idle
    queue_op(OP_TAKE_FIRST);                             // empty buffer
    queue_op(ACT_SPARE_LO);
    queue_op(OP_NONE);
    queue_op(OP_TICK);                                   // empty frame
    queue_event(OP_WRITE_TX, 8'hFF, 8'h00, 9'h1FF);
    queue_event(OP_WRITE_TX, 8'h00, 8'h01, 9'h000);
    queue_event(OP_WRITE_TX, 8'h5A, 8'hFF, 9'h100);
    queue_event(OP_START_TX, 8'h00, 8'h00, 9'h000);      // entry 0 alone
    queue_event(OP_SEND_CHAR, 8'hFF, 8'h00, 9'h000);
    queue_event(OP_START_TX, 8'hFF, 8'hFF, 9'd2);
    queue_event(OP_START_TX, 8'h00, 8'h00, 9'h1FF);      // refused, busy
    queue_event(OP_SEND_CHAR, 8'h00, 8'hFF, 9'h000);     // refused, busy
    queue_op(OP_TX_READY);
    queue_op(OP_TX_READY);                               // past the last byte
    queue_event(OP_RX_BYTE, 8'hFF, 8'h00, 9'h000);
    queue_event(OP_RX_BYTE, 8'h00, 8'hFF, 9'h1FF);
    queue_event(OP_READ_RX, 8'h00, 8'h01, 9'h000);
    queue_op(OP_TICK);                                   // closes the frame
    queue_event(OP_RX_BYTE, 8'h77, 8'h00, 9'h000);       // dropped
    queue_op(OP_TICK);                                   // closed frame
    queue_event(OP_READ_RX, 8'h00, 8'h00, 9'h000);
    queue_op(OP_TAKE_FIRST);
    queue_op(OP_RX_BYTE);
    queue_op(OP_CLEAR_RX);
    queue_event(OP_READ_RX, 8'hFF, 8'h00, 9'h1FF);       // stale entry

    configure(SILENCE_RESET, 16'(RX_MAX_RESET));
    run_traffic(80);
    configure(16'd1, 16'd1);
    run_traffic(80);
    configure(16'd0, 16'd4);                             // silence of zero
    run_traffic(80);
    configure(16'd3, 16'd0);                             // keeps no bytes
    run_traffic(60);
    configure(16'd6, {7'($urandom), 9'd300});            // limit above depth
    run_traffic(60);

    // Longest silence, a frame past the depth, and a full-buffer transmit
    configure(16'hFFFF, 16'd511);
    queue_op(OP_CLEAR_RX);
    repeat (2) queue_op(OP_RX_BYTE);
    repeat (40) queue_op(OP_TICK);                       // frame stays open
    queue_read_rx();
    queue_op(OP_TICK);
    queue_op(OP_RX_BYTE);
    queue_op(OP_TAKE_FIRST);
    repeat (258) queue_op(OP_RX_BYTE);
    queue_event(OP_READ_RX, 8'($urandom), 8'hFF, 9'($urandom));
    queue_op(OP_TAKE_FIRST);
    while (tx_len != 0) queue_op(OP_TX_READY);
    for (int k = 0; k < TX_DEPTH; k++)
      queue_event(OP_WRITE_TX, 8'($urandom), 8'(k), 9'($urandom));
    queue_start_tx(9'($urandom_range(256, 511)));
    while (tx_len != 0) queue_op(OP_TX_READY);
    run_traffic(40);

    repeat (4) begin
      configure(16'($urandom_range(1, 40)), 16'($urandom_range(1, 300)));
      run_traffic(80);
    end

    calm = 1'b1;
    configure(16'd2, 16'd256);
    run_traffic(100);

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_status.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
